// ===== src/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants for the set-associative LRU cache model
// Holds the word formats of both channels, the register map, the access kinds
// and outcome codes, and the controller state encoding.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CntW  = 32;
  localparam int unsigned TagW  = 64;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Register map, indexed by paddr[3:2].
  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_reg_e;

  localparam logic [2:0] SetBitsRst   = 3'd4;
  localparam logic [3:0] WaysRst      = 4'd1;
  localparam logic [5:0] BlockBitsRst = 6'd4;

  typedef enum logic {
    KIND_ACCESS = 1'b0,
    KIND_MODIFY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic             kind;
    logic [AddrW-1:0] address;
  } in_word_t;

  typedef struct packed {
    outcome_e        outcome;
    logic            last;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] eviction_total;
  } out_word_t;

endpackage

// ===== src/salc_set_eval.sv =====
// ----------------------------------------------------------------------------
// salc_set_eval: lookup and LRU update of one cache set
// Takes the stored row of a set and a tag, finds the hit, fill or victim way,
// and returns the updated row together with the access outcome.
// ----------------------------------------------------------------------------
module salc_set_eval #(
  parameter int unsigned MAX_WAYS = 8
) (
  input  logic [MAX_WAYS*(1+salc_pkg::TagW+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] row_i,
  input  logic [salc_pkg::TagW-1:0]                    tag_i,
  input  logic [$clog2(MAX_WAYS+1)-1:0]                nw_i,
  output logic [MAX_WAYS*(1+salc_pkg::TagW+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] row_o,
  output salc_pkg::outcome_e                           outcome_o
);

  localparam int unsigned AgeW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WiW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WnW  = $clog2(MAX_WAYS + 1);
  localparam logic [AgeW-1:0] AgeMax = AgeW'(MAX_WAYS - 1);

  typedef struct packed {
    logic                      valid;
    logic [salc_pkg::TagW-1:0] tag;
    logic [AgeW-1:0]           age;
  } line_t;

  line_t [MAX_WAYS-1:0] row_in;
  line_t [MAX_WAYS-1:0] row_new;
  logic  [MAX_WAYS-1:0] in_use;
  logic  [MAX_WAYS-1:0] hit_vec;
  logic  [MAX_WAYS-1:0] inv_vec;
  logic  [WiW-1:0]      hit_way;
  logic  [WiW-1:0]      inv_way;
  logic  [WiW-1:0]      victim;
  logic  [WiW-1:0]      sel_way;
  logic  [AgeW-1:0]     oldest;
  line_t                sel_line;

  assign row_in = row_i;
  assign row_o  = row_new;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]  = WnW'(i) < nw_i;
      hit_vec[i] = in_use[i] && row_in[i].valid && (row_in[i].tag == tag_i);
      inv_vec[i] = in_use[i] && !row_in[i].valid;
    end
    // Lowest-numbered way wins, so scan from the top down.
    hit_way = '0;
    inv_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = WiW'(i);
      end
      if (inv_vec[i]) begin
        inv_way = WiW'(i);
      end
    end
    // Oldest way; ties go to the lower way number.
    victim = '0;
    oldest = row_in[0].age;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (row_in[i].age > oldest)) begin
        oldest = row_in[i].age;
        victim = WiW'(i);
      end
    end

    if (|hit_vec) begin
      outcome_o = salc_pkg::OUT_HIT;
      sel_way   = hit_way;
    end else if (|inv_vec) begin
      outcome_o = salc_pkg::OUT_FILL;
      sel_way   = inv_way;
    end else begin
      outcome_o = salc_pkg::OUT_EVICT;
      sel_way   = victim;
    end
    sel_line = row_in[sel_way];

    // Valid ages younger than the touched line (all, if it was empty) move back by one, up to the cap.
    row_new = row_in;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && (WiW'(i) != sel_way) && row_in[i].valid &&
          (!sel_line.valid || (row_in[i].age < sel_line.age)) &&
          (row_in[i].age < AgeMax)) begin
        row_new[i].age = row_in[i].age + AgeW'(1);
      end
    end
    row_new[sel_way].age   = '0;
    row_new[sel_way].valid = 1'b1;
    row_new[sel_way].tag   = tag_i;
  end

endmodule

// ===== src/set_assoc_lru_cache_sim_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top: tag store of a set-associative LRU cache
// An address word comes in on the input channel; one outcome word per cache
// access goes out, with running hit, miss and eviction totals.
//
// Usage. Input words carry a kind and a 64-bit byte address. An access
// word makes one access and gives one output word; a modify word makes two
// accesses to the same address and gives two output words, the second marked
// with last. Each output word reports hit, fill of an empty way, or eviction,
// plus the saturating totals after that access.
// Access loop. An access reads the set row from the tag memory as its word is
// accepted in the idle state, then in the evaluate state writes the row back
// and loads the output register. The second access of a modify word reuses
// the written row through the read register, with a second evaluate step and
// no second read. A new word is accepted only when the controller is idle, so
// the block takes no new word before it is through with the last one.
// Reset. After reset the block sweeps the set memory once, one row per cycle,
// over all 2**MAX_SET_BITS rows, and accepts no input word until that is done.
// Configuration writes over the APB port are taken at any time.
// Stall. When the receiver holds out_ready_i low, the result waits in the
// output register and the evaluation stage holds its row until it drains.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  salc_pkg::in_word_t  in_word_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output salc_pkg::out_word_t out_word_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned Sets  = 1 << MAX_SET_BITS;
  localparam int unsigned SiW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned AgeW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned LineW = 1 + salc_pkg::TagW + AgeW;
  localparam int unsigned RowW  = MAX_WAYS * LineW;
  localparam int unsigned WnW   = $clog2(MAX_WAYS + 1);
  localparam logic [SiW-1:0] LastSet = SiW'(Sets - 1);

  // Configuration registers.
  logic [2:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;
  logic       cfg_we;

  // Controller.
  salc_pkg::state_e state_q, state_d;
  logic [SiW-1:0]   clr_idx_q;
  logic             second_q;
  logic             kind_q;
  logic [SiW-1:0]   set_q;
  logic [salc_pkg::TagW-1:0] tag_q;
  logic             accept;
  logic             step;

  // Address split.
  logic [2:0]                 sb;
  logic [6:0]                 tag_shift;
  logic [salc_pkg::AddrW-1:0] addr_sh;
  logic [SiW-1:0]             idx_mask;
  logic [SiW-1:0]             set_idx;
  logic [salc_pkg::TagW-1:0]  tag_idx;
  logic [WnW-1:0]             nw;

  // Set memory.
  logic [RowW-1:0] mem_q [Sets];
  logic [RowW-1:0] row_q;
  logic [RowW-1:0] row_new;
  logic            mem_we;
  logic [SiW-1:0]  mem_wa;
  logic [RowW-1:0] mem_wd;

  salc_pkg::outcome_e outcome;

  // Totals and output register.
  logic [salc_pkg::CntW-1:0] hits_q, hits_d;
  logic [salc_pkg::CntW-1:0] misses_q, misses_d;
  logic [salc_pkg::CntW-1:0] evictions_q, evictions_d;
  logic                      out_valid_q;
  salc_pkg::out_word_t       out_word_q;

  // --------------------------------------------------------------------------
  // APB register port. Zero wait states; the word index is paddr[3:2].
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= salc_pkg::SetBitsRst;
      ways_q       <= salc_pkg::WaysRst;
      block_bits_q <= salc_pkg::BlockBitsRst;
    end else if (cfg_we) begin
      case (paddr[3:2])
        salc_pkg::CFG_SET_BITS:   set_bits_q   <= pwdata[2:0];
        salc_pkg::CFG_WAYS:       ways_q       <= pwdata[3:0];
        salc_pkg::CFG_BLOCK_BITS: block_bits_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      salc_pkg::CFG_SET_BITS:   prdata = {29'd0, set_bits_q};
      salc_pkg::CFG_WAYS:       prdata = {28'd0, ways_q};
      salc_pkg::CFG_BLOCK_BITS: prdata = {26'd0, block_bits_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Address split. The set index sits just above the block offset; the tag is
  // everything above the set index, and a shift of 64 or more leaves zero.
  // --------------------------------------------------------------------------
  always_comb begin
    if (32'(set_bits_q) > MAX_SET_BITS) begin
      sb = 3'(MAX_SET_BITS);
    end else begin
      sb = set_bits_q;
    end
    tag_shift = {1'b0, block_bits_q} + {4'd0, sb};
    addr_sh   = in_word_i.address >> block_bits_q;
    for (int i = 0; i < SiW; i++) begin
      idx_mask[i] = i < int'(sb);
    end
    set_idx = addr_sh[SiW-1:0] & idx_mask;
    if (tag_shift >= 7'd64) begin
      tag_idx = '0;
    end else begin
      tag_idx = in_word_i.address >> tag_shift;
    end
  end

  // Effective way count: zero acts as one, anything above MAX_WAYS is capped.
  always_comb begin
    if (ways_q == 4'd0) begin
      nw = WnW'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      nw = WnW'(MAX_WAYS);
    end else begin
      nw = WnW'(ways_q);
    end
  end

  // --------------------------------------------------------------------------
  // Controller: clear sweep, then idle / evaluate per access.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    step       = 1'b0;
    case (state_q)
      salc_pkg::ST_CLEAR: begin
        if (clr_idx_q == LastSet) begin
          state_d = salc_pkg::ST_IDLE;
        end
      end
      salc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = salc_pkg::ST_EVAL;
        end
      end
      salc_pkg::ST_EVAL: begin
        if (!out_valid_q || out_ready_i) begin
          step = 1'b1;
          if ((kind_q == salc_pkg::KIND_MODIFY) && !second_q) begin
            state_d = salc_pkg::ST_EVAL;
          end else begin
            state_d = salc_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = salc_pkg::ST_IDLE;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= salc_pkg::ST_CLEAR;
      clr_idx_q <= '0;
      second_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == salc_pkg::ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + SiW'(1);
      end
      if (accept) begin
        second_q <= 1'b0;
      end else if (step) begin
        second_q <= (kind_q == salc_pkg::KIND_MODIFY) && !second_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_word_i.kind;
      set_q  <= set_idx;
      tag_q  <= tag_idx;
    end
  end

  // --------------------------------------------------------------------------
  // Set memory: one row per set, all ways side by side. The read register is
  // also loaded with the written row, so the second access of a modify sees
  // its own update without a second read.
  // --------------------------------------------------------------------------
  assign mem_we = (state_q == salc_pkg::ST_CLEAR) || step;
  assign mem_wa = (state_q == salc_pkg::ST_CLEAR) ? clr_idx_q : set_q;
  assign mem_wd = (state_q == salc_pkg::ST_CLEAR) ? '0 : row_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= mem_q[set_idx];
    end else if (step) begin
      row_q <= row_new;
    end
  end

  salc_set_eval #(
    .MAX_WAYS (MAX_WAYS)
  ) u_set_eval (
    .row_i     (row_q),
    .tag_i     (tag_q),
    .nw_i      (nw),
    .row_o     (row_new),
    .outcome_o (outcome)
  );

  // --------------------------------------------------------------------------
  // Saturating totals and the output register.
  // --------------------------------------------------------------------------
  always_comb begin
    hits_d      = hits_q;
    misses_d    = misses_q;
    evictions_d = evictions_q;
    if (outcome == salc_pkg::OUT_HIT) begin
      if (hits_q != salc_pkg::CntMax) begin
        hits_d = hits_q + salc_pkg::CntW'(1);
      end
    end else begin
      if (misses_q != salc_pkg::CntMax) begin
        misses_d = misses_q + salc_pkg::CntW'(1);
      end
      if ((outcome == salc_pkg::OUT_EVICT) && (evictions_q != salc_pkg::CntMax)) begin
        evictions_d = evictions_q + salc_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evictions_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        evictions_q <= evictions_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_word_q.outcome        <= outcome;
      out_word_q.last           <= (kind_q != salc_pkg::KIND_MODIFY) || second_q;
      out_word_q.hit_total      <= hits_d;
      out_word_q.miss_total     <= misses_d;
      out_word_q.eviction_total <= evictions_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // An accepted word always starts with the first access of its evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == salc_pkg::ST_EVAL) && !second_q)
    else $error("accepted word did not enter evaluation");

  // A result is never written over one that the receiver has not yet taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_word_q) && out_valid_q)
    else $error("pending result was overwritten");

  // Totals never go backward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)) &&
             (evictions_q >= $past(evictions_q)))
    else $error("running total decreased");

  // No result leaves and no word is taken during the clearing sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == salc_pkg::ST_CLEAR) |-> !out_valid_o && !in_ready_o)
    else $error("traffic during clearing sweep");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the set-associative LRU cache tag store
// Address words go in over a valid/ready channel and outcome words come back
// over another. A model of the tag store, written here, predicts every outcome
// word and its hit, miss and eviction totals. The run walks a short table of
// directed cases first, then random phases under changing geometry, with
// random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSetBits = 6;
  localparam int MaxWays    = 8;
  localparam int LineCount  = (1 << MaxSetBits) * MaxWays;

  // Slowest correct run: about 610 words, each a modify (two results), each
  // result held by the longest receiver gap and each word by the longest sender
  // gap, plus the access loop. Add the clearing sweep, the long hold-off and the
  // drains, then leave plenty of margin.
  localparam int CycleLimit = 800_000;
  localparam int LongHold   = 250;
  localparam int TailCycles = 10;
  localparam int NumPhases  = 9;
  localparam int PhaseWords = 65;
  localparam int PoolMax    = 32;
  localparam int ShownMax   = 10;

  // Directed table. A row either writes a register or sends one word. Where
  // known is set, the final outcome word of that row is typed in by hand.
  typedef enum logic [1:0] {
    OP_CFG,
    OP_ACCESS,
    OP_MODIFY
  } row_op_e;

  typedef struct packed {
    row_op_e            op;
    salc_pkg::cfg_reg_e reg_idx;
    logic [63:0]        arg;
    logic               known;
    salc_pkg::outcome_e outcome;
    logic [31:0]        hits;
    logic [31:0]        misses;
    logic [31:0]        evicts;
  } dir_row_t;

  localparam int NumDir = 31;
  localparam dir_row_t DirTable [NumDir] = '{
    // Reset geometry: 16 sets, one way, 16-byte blocks.
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h0, 1'b1, salc_pkg::OUT_FILL,
      32'd0, 32'd1, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h8, 1'b1, salc_pkg::OUT_HIT,
      32'd1, 32'd1, 32'd0},
    '{OP_MODIFY, salc_pkg::CFG_SET_BITS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, salc_pkg::OUT_HIT,
      32'd2, 32'd2, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h100, 1'b1, salc_pkg::OUT_EVICT,
      32'd2, 32'd3, 32'd1},
    '{OP_MODIFY, salc_pkg::CFG_SET_BITS, 64'h0, 1'b1, salc_pkg::OUT_HIT,
      32'd3, 32'd4, 32'd2},
    // A way count of zero behaves as one.
    '{OP_CFG, salc_pkg::CFG_WAYS, 64'd0, 1'b0, salc_pkg::OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h100, 1'b1, salc_pkg::OUT_EVICT,
      32'd3, 32'd5, 32'd3},
    // Oversized way and set counts clamp to eight ways and 64 sets.
    '{OP_CFG, salc_pkg::CFG_WAYS, 64'd15, 1'b0, salc_pkg::OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{OP_CFG, salc_pkg::CFG_SET_BITS, 64'd7, 1'b0, salc_pkg::OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{OP_CFG, salc_pkg::CFG_BLOCK_BITS, 64'd0, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    // The line stored under the old split still matches its old tag.
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h40, 1'b1, salc_pkg::OUT_HIT,
      32'd4, 32'd5, 32'd3},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h80, 1'b1, salc_pkg::OUT_FILL,
      32'd4, 32'd6, 32'd3},
    // Fill the rest of set 0, then force LRU evictions.
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'hC0, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h100, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h140, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h180, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h1C0, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h200, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h240, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_MODIFY, salc_pkg::CFG_SET_BITS, 64'h40, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    // Offset plus index reaches 64 bits: the tag collapses to zero.
    '{OP_CFG, salc_pkg::CFG_BLOCK_BITS, 64'd63, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_CFG, salc_pkg::CFG_SET_BITS, 64'd1, 1'b0, salc_pkg::OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h8000_0000_0000_0000, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h0, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    // A single set with wide blocks.
    '{OP_CFG, salc_pkg::CFG_SET_BITS, 64'd0, 1'b0, salc_pkg::OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{OP_CFG, salc_pkg::CFG_BLOCK_BITS, 64'd32, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_CFG, salc_pkg::CFG_WAYS, 64'd8, 1'b0, salc_pkg::OUT_HIT, 32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h1234_5678_9ABC_DEF0, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_MODIFY, salc_pkg::CFG_SET_BITS, 64'h1234_5678_9ABC_DEF0, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0},
    '{OP_ACCESS, salc_pkg::CFG_SET_BITS, 64'h0000_0000_FFFF_FFFF, 1'b0, salc_pkg::OUT_HIT,
      32'd0, 32'd0, 32'd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  salc_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  salc_pkg::out_word_t out_word_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Local copy of the tag store and its registers.
  logic        line_valid [LineCount];
  logic [63:0] line_tag   [LineCount];
  logic [2:0]  line_age   [LineCount];
  logic [31:0] hit_tally;
  logic [31:0] miss_tally;
  logic [31:0] evict_count;
  logic [2:0]  cfg_set_bits;
  logic [3:0]  cfg_ways;
  logic [5:0]  cfg_block_bits;

  // Outcome words predicted but not yet seen, oldest first.
  salc_pkg::out_word_t predicted_words [$];

  int          fail_count = 0;
  int          cycle_count = 0;
  logic        steady;          // both sides run without gaps while set
  logic        long_hold_req;   // asks the receiver for one long hold-off
  logic        long_hold_done;  // set by the receiver once the hold-off ran

  set_assoc_lru_cache_sim_top #(
    .MAX_SET_BITS(MaxSetBits),
    .MAX_WAYS    (MaxWays)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none in a steady stretch.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] sat_bump(logic [31:0] count);
    return (count == salc_pkg::CntMax) ? count : count + 32'd1;
  endfunction

  // Make way w the most recent line of its set. Only valid lines younger
  // than w's old rank age by one, and no rank grows past MaxWays - 1.
  function automatic void refresh_rank(int base, int nw, int w);
    int prior;
    int i;
    prior = line_valid[base + w] ? int'(line_age[base + w]) : MaxWays;
    for (i = 0; i < nw; i++) begin
      if (i != w && line_valid[base + i] && int'(line_age[base + i]) < prior &&
          int'(line_age[base + i]) < MaxWays - 1) begin
        line_age[base + i] = line_age[base + i] + 3'd1;
      end
    end
    line_age[base + w] = 3'd0;
  endfunction

  // One lookup in the tag store; updates lines, ranks and totals.
  function automatic salc_pkg::outcome_e cache_access(logic [63:0] address);
    int          sb;
    int          nw;
    int          shift;
    int          set_idx;
    int          base;
    int          victim;
    int          oldest;
    int          i;
    logic [63:0] tag;
    logic [63:0] index_bits;
    sb = (cfg_set_bits > 3'(MaxSetBits)) ? MaxSetBits : int'(cfg_set_bits);
    if (cfg_ways == 4'd0) nw = 1;
    else nw = (cfg_ways > 4'(MaxWays)) ? MaxWays : int'(cfg_ways);
    index_bits = address >> cfg_block_bits;
    set_idx = int'(index_bits & ((64'd1 << sb) - 64'd1));
    shift = int'(cfg_block_bits) + sb;
    tag = (shift >= 64) ? 64'd0 : (address >> shift);
    base = set_idx * MaxWays;
    victim = 0;
    oldest = 0;

    for (i = 0; i < nw; i++) begin
      if (line_valid[base + i] && line_tag[base + i] == tag) begin
        hit_tally = sat_bump(hit_tally);
        refresh_rank(base, nw, i);
        return salc_pkg::OUT_HIT;
      end
    end
    miss_tally = sat_bump(miss_tally);
    for (i = 0; i < nw; i++) begin
      if (!line_valid[base + i]) begin
        refresh_rank(base, nw, i);
        line_valid[base + i] = 1'b1;
        line_tag[base + i] = tag;
        return salc_pkg::OUT_FILL;
      end
    end
    // Oldest rank wins; on a tie the lowest way is kept as victim.
    for (i = 0; i < nw; i++) begin
      if (i == 0 || int'(line_age[base + i]) > oldest) begin
        oldest = int'(line_age[base + i]);
        victim = i;
      end
    end
    evict_count = sat_bump(evict_count);
    refresh_rank(base, nw, victim);
    line_tag[base + victim] = tag;
    return salc_pkg::OUT_EVICT;
  endfunction

  // Queue the outcome words that one accepted address word must produce.
  function automatic void predict_word(salc_pkg::in_word_t w);
    int                  n;
    int                  k;
    salc_pkg::out_word_t r;
    n = (w.kind == salc_pkg::KIND_MODIFY) ? 2 : 1;
    for (k = 0; k < n; k++) begin
      r.outcome = cache_access(w.address);
      r.last = (k == n - 1);
      r.hit_total = hit_tally;
      r.miss_total = miss_tally;
      r.eviction_total = evict_count;
      predicted_words.push_back(r);
    end
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  // Valid is lowered only when a gap follows, so it never drops and rises
  // within one time step.
  task automatic send_word(salc_pkg::in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(w);
  endtask

  // APB write: setup phase, access phase until pready, then an idle phase so
  // that back-to-back writes never touch psel twice in the same step.
  task automatic write_reg(salc_pkg::cfg_reg_e idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      salc_pkg::CFG_SET_BITS:   cfg_set_bits = value[2:0];
      salc_pkg::CFG_WAYS:       cfg_ways = value[3:0];
      salc_pkg::CFG_BLOCK_BITS: cfg_block_bits = value[5:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (predicted_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic void log_mismatch(string what, salc_pkg::out_word_t exp_w,
                                       salc_pkg::out_word_t got_w);
    fail_count++;
    if (fail_count <= ShownMax) begin
      $display("%s: expected outcome=%0d last=%0b hits=%0d misses=%0d evictions=%0d",
               what, exp_w.outcome, exp_w.last, exp_w.hit_total, exp_w.miss_total,
               exp_w.eviction_total);
      $display("%s: got      outcome=%0d last=%0b hits=%0d misses=%0d evictions=%0d",
               what, got_w.outcome, got_w.last, got_w.hit_total, got_w.miss_total,
               got_w.eviction_total);
    end
  endfunction

  // Every outcome word taken from the block is matched against the oldest
  // prediction, field by field. A word with nothing waiting is a failure.
  always @(posedge clk_i) begin
    salc_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_words.size() == 0) begin
        log_mismatch("unexpected word", '0, out_word_o);
      end else begin
        exp_w = predicted_words.pop_front();
        if (out_word_o.outcome !== exp_w.outcome || out_word_o.last !== exp_w.last ||
            out_word_o.hit_total !== exp_w.hit_total ||
            out_word_o.miss_total !== exp_w.miss_total ||
            out_word_o.eviction_total !== exp_w.eviction_total) begin
          log_mismatch("outcome mismatch", exp_w, out_word_o);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver side. Ready toggles with random gaps; once per run it holds
  // off for the LongHold stretch while the sender keeps offering words, so the
  // output register fills and the block has to stall its input.
  initial begin : receiver
    int gap;
    long_hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int                  i;
    int                  phase;
    int                  n;
    int                  pool_size;
    int                  bit_pos;
    int                  roll;
    dir_row_t            row;
    salc_pkg::in_word_t  w;
    salc_pkg::out_word_t typed;
    logic [63:0]         region;
    logic [63:0]         addr;
    logic [63:0]         offset_mask;
    logic [31:0]         sb_v;
    logic [31:0]         ways_v;
    logic [31:0]         bb_v;
    logic [63:0]         hot_lines [PoolMax];

    // Every input known from time zero; reset held low, then released.
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    long_hold_req = 1'b0;
    for (i = 0; i < LineCount; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i] = '0;
      line_age[i] = '0;
    end
    hit_tally = '0;
    miss_tally = '0;
    evict_count = '0;
    cfg_set_bits = salc_pkg::SetBitsRst;
    cfg_ways = salc_pkg::WaysRst;
    cfg_block_bits = salc_pkg::BlockBitsRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. The block sweeps its set memory after reset; the
    // first word simply waits on ready until that is over.
    for (i = 0; i < NumDir; i++) begin
      row = DirTable[i];
      if (row.op == OP_CFG) begin
        // Registers change only once every predicted word has come back.
        in_valid_i <= 1'b0;
        wait_drained();
        write_reg(row.reg_idx, row.arg[31:0]);
      end else begin
        w.kind = (row.op == OP_MODIFY) ? salc_pkg::KIND_MODIFY : salc_pkg::KIND_ACCESS;
        w.address = row.arg;
        send_word(w);
        if (row.known) begin
          // Hand-typed final word replaces the predicted one.
          typed.outcome = row.outcome;
          typed.last = 1'b1;
          typed.hit_total = row.hits;
          typed.miss_total = row.misses;
          typed.eviction_total = row.evicts;
          void'(predicted_words.pop_back());
          predicted_words.push_back(typed);
        end
      end
    end

    // Random phases. Each phase picks a geometry (the first few are the
    // extremes), then sends words that mostly revisit a small pool of hot
    // blocks whose index bits collide, so hits, fills and evictions all
    // show up. The rest flips single address bits or is fully random.
    for (phase = 0; phase < NumPhases; phase++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      case (phase)
        0: begin sb_v = 32'd6; ways_v = 32'd8;  bb_v = 32'd0;  end
        1: begin sb_v = 32'd0; ways_v = 32'd1;  bb_v = 32'd63; end
        2: begin sb_v = 32'd7; ways_v = 32'd15; bb_v = 32'd32; end
        3: begin sb_v = 32'd2; ways_v = 32'd0;  bb_v = 32'd5;  end
        default: begin
          sb_v = $urandom_range(0, 7);
          ways_v = $urandom_range(0, 15);
          roll = $urandom_range(0, 99);
          if (roll < 70) bb_v = $urandom_range(0, 12);
          else if (roll < 85) bb_v = $urandom_range(13, 40);
          else bb_v = $urandom_range(41, 63);
        end
      endcase
      write_reg(salc_pkg::CFG_SET_BITS, sb_v);
      write_reg(salc_pkg::CFG_WAYS, ways_v);
      write_reg(salc_pkg::CFG_BLOCK_BITS, bb_v);

      steady = (phase % 3 == 2);
      if (phase == 0) long_hold_req = 1'b1;

      region = {$urandom, $urandom};
      pool_size = $urandom_range(2, PoolMax);
      for (n = 0; n < pool_size; n++) begin
        hot_lines[n] = region ^ (64'($urandom_range(0, 511)) << cfg_block_bits);
      end
      offset_mask = (64'd1 << cfg_block_bits) - 64'd1;

      for (n = 0; n < PhaseWords; n++) begin
        roll = $urandom_range(0, 99);
        addr = hot_lines[$urandom_range(0, pool_size - 1)];
        if (roll < 75) begin
          addr = addr ^ ({$urandom, $urandom} & offset_mask);
        end else if (roll < 90) begin
          bit_pos = $urandom_range(0, 63);
          addr[bit_pos] = ~addr[bit_pos];
        end else begin
          addr = {$urandom, $urandom};
        end
        w.kind = ($urandom_range(0, 99) < 30) ? salc_pkg::KIND_MODIFY
                                                : salc_pkg::KIND_ACCESS;
        w.address = addr;
        send_word(w);
      end
    end

    // Let the last words drain, wait out TailCycles so the block can show
    // any stray output, then report.
    in_valid_i <= 1'b0;
    steady = 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && predicted_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
